[hdl/sctm_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sctm_pkg
// shared widths, codes and types for the scan cycle timing monitor
// ----------------------------------------------------------------------------
package sctm_pkg;

  localparam int TIME_BITS     = 48;
  localparam int SUM_BITS      = 64;
  localparam int FIELD_BITS    = 48;
  localparam int INTERVAL_BITS = 24;
  localparam int WINDOW_BITS   = 21;
  localparam int CFG_DATA_BITS = 24;
  localparam int CFG_IDX_BITS  = 2;
  localparam int OP_BITS       = 2;
  localparam int NUM_STATS     = 3;
  localparam int OUT_FIELDS    = 11;
  localparam int OUT_BITS      = OUT_FIELDS * FIELD_BITS;

  // quotient bits retired per divider cycle
  localparam int DIV_DIGIT     = 2;

  localparam logic [CFG_IDX_BITS-1:0] REG_INTERVAL = CFG_IDX_BITS'(0);
  localparam logic [CFG_IDX_BITS-1:0] REG_WINDOW   = CFG_IDX_BITS'(1);

  localparam logic [OP_BITS-1:0] OP_START = OP_BITS'(0);
  localparam logic [OP_BITS-1:0] OP_END   = OP_BITS'(1);
  localparam logic [OP_BITS-1:0] OP_SNAP  = OP_BITS'(2);

  localparam logic [INTERVAL_BITS-1:0] RESET_INTERVAL = INTERVAL_BITS'(1000);
  localparam logic [WINDOW_BITS-1:0]   RESET_WINDOW   = WINDOW_BITS'(2000);

  localparam logic [FIELD_BITS-1:0] FIELD_MAX = {1'b0, {(FIELD_BITS-1){1'b1}}};
  localparam logic [FIELD_BITS-1:0] FIELD_MIN = {1'b1, {(FIELD_BITS-1){1'b0}}};

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

[hdl/sctm_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sctm_div
// serial signed divider by the window, two quotient bits per cycle
// ----------------------------------------------------------------------------
module sctm_div (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic [sctm_pkg::SUM_BITS-1:0]       dividend,
  input  logic [sctm_pkg::WINDOW_BITS-1:0]    divisor,
  output logic [sctm_pkg::SUM_BITS-1:0]       quotient,
  output sctm_pkg::div_stat_t                 stat
);
  import sctm_pkg::*;

  localparam int DIV_ITERS    = SUM_BITS / DIV_DIGIT;
  localparam int DIV_CNT_BITS = $clog2(DIV_ITERS);

  logic                     busy_r, fin_r, done_r, neg_r;
  logic [DIV_CNT_BITS-1:0]  cnt_r;
  logic [SUM_BITS-1:0]      quo_r, quo_nxt, q_r;
  logic [WINDOW_BITS-1:0]   rem_r, rem_nxt, dvs_r;
  logic [WINDOW_BITS:0]     trial;

  // restoring steps, msb of the magnitude shifts into the remainder
  always_comb begin
    rem_nxt = rem_r;
    quo_nxt = quo_r;
    trial   = '0;
    for (int i = 0; i < DIV_DIGIT; i++) begin
      trial   = {rem_nxt, quo_nxt[SUM_BITS-1]};
      quo_nxt = {quo_nxt[SUM_BITS-2:0], 1'b0};
      if (trial >= {1'b0, dvs_r}) begin
        trial      = trial - {1'b0, dvs_r};
        quo_nxt[0] = 1'b1;
      end
      rem_nxt = trial[WINDOW_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fin_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        neg_r  <= dividend[SUM_BITS-1];
        quo_r  <= dividend[SUM_BITS-1] ? (~dividend + SUM_BITS'(1)) : dividend;
        rem_r  <= '0;
        // a zero window acts as one
        dvs_r  <= (divisor == '0) ? WINDOW_BITS'(1) : divisor;
      end else if (busy_r) begin
        quo_r <= quo_nxt;
        rem_r <= rem_nxt;
        cnt_r <= cnt_r + DIV_CNT_BITS'(1);
        if (cnt_r == DIV_CNT_BITS'(DIV_ITERS - 1)) begin
          busy_r <= 1'b0;
          fin_r  <= 1'b1;
        end
      end else if (fin_r) begin
        q_r    <= neg_r ? (~quo_r + SUM_BITS'(1)) : quo_r;
        fin_r  <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  assign quotient  = q_r;
  assign stat.busy = busy_r | fin_r;
  assign stat.done = done_r;

endmodule

[hdl/sctm_rec.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sctm_rec
// statistic update: saturating ewma add, running minimum and maximum
// ----------------------------------------------------------------------------
module sctm_rec (
  input  logic [sctm_pkg::SUM_BITS-1:0]   decayed,
  input  logic [sctm_pkg::FIELD_BITS-1:0] sample,
  input  logic [sctm_pkg::FIELD_BITS-1:0] cur_min,
  input  logic [sctm_pkg::FIELD_BITS-1:0] cur_max,
  output logic [sctm_pkg::SUM_BITS-1:0]   sum_nxt,
  output logic [sctm_pkg::FIELD_BITS-1:0] min_nxt,
  output logic [sctm_pkg::FIELD_BITS-1:0] max_nxt
);
  import sctm_pkg::*;

  localparam logic [SUM_BITS-1:0] SUM_MAX = {1'b0, {(SUM_BITS-1){1'b1}}};
  localparam logic [SUM_BITS-1:0] SUM_MIN = {1'b1, {(SUM_BITS-1){1'b0}}};

  logic [SUM_BITS:0] total;

  always_comb begin
    total = {decayed[SUM_BITS-1], decayed}
          + {{(SUM_BITS+1-FIELD_BITS){sample[FIELD_BITS-1]}}, sample};
    if (total[SUM_BITS] != total[SUM_BITS-1]) begin
      sum_nxt = total[SUM_BITS] ? SUM_MIN : SUM_MAX;
    end else begin
      sum_nxt = total[SUM_BITS-1:0];
    end
    min_nxt = ($signed(sample) < $signed(cur_min)) ? sample : cur_min;
    max_nxt = ($signed(sample) > $signed(cur_max)) ? sample : cur_max;
  end

endmodule

[hdl/scan_cycle_timing_monitor.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scan_cycle_timing_monitor
// scan time, cycle time and lateness statistics of a periodic task
// ----------------------------------------------------------------------------
// usage
//   in_*  : one word per event; in_tuser holds the operation (cycle start,
//           cycle end, snapshot), in_tdata the 48-bit timestamp in us
//   out_* : one word per snapshot; out_tuser is stats_valid, out_tdata
//           the eleven statistics fields
//   cfg_* : register writes (interval, window), only while idle
// timing
//   one event at a time; in_tready is high only when the sequencer idles
//   the first cycle start and unknown operations return straight to idle
//   each divider pass runs launch, serial steps at two quotient bits
//   each, sign fix and hand-off; a sample adds an update step after its
//   pass; an end takes one pass, a later start two and a snapshot three,
//   and the snapshot then loads its word
// reset
//   synchronous, active low; registers return to 1000 us and 2000, all
//   counters, anchors and sums clear, minimums go to the largest value
// stall
//   the snapshot word waits in the output register; new events are
//   taken meanwhile, a second snapshot holds until the first is taken
// ----------------------------------------------------------------------------
module scan_cycle_timing_monitor (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // input channel
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  input  logic [sctm_pkg::TIME_BITS-1:0]        in_tdata,  // timestamp_us
  input  logic [sctm_pkg::OP_BITS-1:0]          in_tuser,  // operation
  // result channel
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  // start count, scan min/max/avg, period min/max/avg,
  // latency_min/max/avg, overrun_count (48 bits each, lowest first)
  output logic [sctm_pkg::OUT_BITS-1:0]         out_tdata,
  output logic                                  out_tuser, // stats_valid
  // configuration port
  input  logic                                  cfg_we,
  input  logic [sctm_pkg::CFG_IDX_BITS-1:0]     cfg_index,
  input  logic [sctm_pkg::CFG_DATA_BITS-1:0]    cfg_wdata
);
  import sctm_pkg::*;

  // statistic slots
  localparam logic [1:0] K_SCAN  = 2'd0;
  localparam logic [1:0] K_CYCLE = 2'd1;
  localparam logic [1:0] K_LAT   = 2'd2;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,  // waiting for an event
    S_GO   = 5'b00010,  // launch divider on the selected sum
    S_DIV  = 5'b00100,  // wait for sum / window
    S_UPD  = 5'b01000,  // fold the sample into the statistic
    S_OUT  = 5'b10000   // load the snapshot word
  } state_t;

  state_t state_r;

  // configuration
  logic [INTERVAL_BITS-1:0] interval_r;
  logic [WINDOW_BITS-1:0]   window_r;

  // architectural state
  logic [FIELD_BITS-1:0] count_r;
  logic [TIME_BITS-1:0]  last_r;
  logic [TIME_BITS-1:0]  proj_r;
  logic [FIELD_BITS-1:0] overrun_r;
  logic [FIELD_BITS-1:0] min_r [NUM_STATS];
  logic [FIELD_BITS-1:0] max_r [NUM_STATS];
  logic [SUM_BITS-1:0]   sums_r [NUM_STATS];

  // per-event working registers
  logic [OP_BITS-1:0]    op_r;
  logic [TIME_BITS-1:0]  ts_r;
  logic [FIELD_BITS-1:0] x_last_r;   // time since last start
  logic [FIELD_BITS-1:0] x_proj_r;   // time since projected start
  logic [1:0]            k_r;
  logic [1:0]            k_end_r;
  logic [SUM_BITS-1:0]   decay_r;    // sum - sum/window
  logic [FIELD_BITS-1:0] avg_r [NUM_STATS];

  // output register
  logic                  out_valid_r;
  logic [OUT_BITS-1:0]   out_data_r;
  logic                  out_user_r;

  logic                  in_acc;
  logic                  div_start;
  logic [SUM_BITS-1:0]   div_q;
  div_stat_t             div_stat;
  logic [FIELD_BITS-1:0] x_cur;
  logic [SUM_BITS-1:0]   rec_sum;
  logic [FIELD_BITS-1:0] rec_min, rec_max;

  // exact signed difference clamped to the field range
  function automatic logic [FIELD_BITS-1:0] sat_diff(input logic [TIME_BITS-1:0] a,
                                                     input logic [TIME_BITS-1:0] b);
    logic [TIME_BITS:0] d;
    d = {1'b0, a} - {1'b0, b};
    if (d[TIME_BITS:FIELD_BITS-1] == '0 || d[TIME_BITS:FIELD_BITS-1] == '1) begin
      return d[FIELD_BITS-1:0];
    end
    return d[TIME_BITS] ? FIELD_MIN : FIELD_MAX;
  endfunction

  function automatic logic [FIELD_BITS-1:0] sat_avg(input logic [SUM_BITS-1:0] v);
    if (v[SUM_BITS-1:FIELD_BITS-1] == '0 || v[SUM_BITS-1:FIELD_BITS-1] == '1) begin
      return v[FIELD_BITS-1:0];
    end
    return v[SUM_BITS-1] ? FIELD_MIN : FIELD_MAX;
  endfunction

  function automatic logic [FIELD_BITS-1:0] inc_sat(input logic [FIELD_BITS-1:0] c);
    return (&c) ? c : c + FIELD_BITS'(1);
  endfunction

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid & in_tready;
  assign div_start = (state_r == S_GO);
  assign x_cur     = (k_r == K_LAT) ? x_proj_r : x_last_r;

  sctm_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (sums_r[k_r]),
    .divisor  (window_r),
    .quotient (div_q),
    .stat     (div_stat)
  );

  sctm_rec u_rec (
    .decayed (decay_r),
    .sample  (x_cur),
    .cur_min (min_r[k_r]),
    .cur_max (max_r[k_r]),
    .sum_nxt (rec_sum),
    .min_nxt (rec_min),
    .max_nxt (rec_max)
  );

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      interval_r <= RESET_INTERVAL;
      window_r   <= RESET_WINDOW;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_INTERVAL: interval_r <= cfg_wdata[INTERVAL_BITS-1:0];
        REG_WINDOW:   window_r   <= cfg_wdata[WINDOW_BITS-1:0];
        default: ;  // unknown index ignored
      endcase
    end
  end

  // sequencer and statistics
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      last_r      <= '0;
      proj_r      <= '0;
      overrun_r   <= '0;
      out_valid_r <= 1'b0;
      k_r         <= K_SCAN;
      k_end_r     <= K_SCAN;
      for (int i = 0; i < NUM_STATS; i++) begin
        min_r[i]  <= FIELD_MAX;
        max_r[i]  <= '0;
        sums_r[i] <= '0;
      end
    end else begin
      // the load state drives the valid flag itself
      if (out_valid_r && out_tready && state_r != S_OUT) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            op_r     <= in_tuser;
            ts_r     <= in_tdata;
            x_last_r <= sat_diff(in_tdata, last_r);
            x_proj_r <= sat_diff(in_tdata, proj_r);
            case (in_tuser)
              OP_START: begin
                if (count_r == '0) begin
                  // first start seeds the anchors
                  proj_r  <= in_tdata + TIME_BITS'(interval_r);
                  last_r  <= in_tdata;
                  count_r <= inc_sat(count_r);
                end else begin
                  k_r     <= K_CYCLE;
                  k_end_r <= K_LAT;
                  state_r <= S_GO;
                end
              end
              OP_END: begin
                if (in_tdata > proj_r) begin
                  overrun_r <= inc_sat(overrun_r);
                end
                k_r     <= K_SCAN;
                k_end_r <= K_SCAN;
                state_r <= S_GO;
              end
              OP_SNAP: begin
                k_r     <= K_SCAN;
                k_end_r <= K_LAT;
                state_r <= S_GO;
              end
              default: ;  // unknown operation is dropped
            endcase
          end
        end
        S_GO: begin
          state_r <= S_DIV;
        end
        S_DIV: begin
          if (div_stat.done) begin
            decay_r    <= sums_r[k_r] - div_q;
            avg_r[k_r] <= sat_avg(div_q);
            if (op_r == OP_SNAP) begin
              if (k_r == k_end_r) begin
                state_r <= S_OUT;
              end else begin
                k_r     <= k_r + 2'd1;
                state_r <= S_GO;
              end
            end else begin
              state_r <= S_UPD;
            end
          end
        end
        S_UPD: begin
          sums_r[k_r] <= rec_sum;
          min_r[k_r]  <= rec_min;
          max_r[k_r]  <= rec_max;
          if (k_r == k_end_r) begin
            if (op_r == OP_START) begin
              // advance the projection after both samples are folded
              proj_r  <= proj_r + TIME_BITS'(interval_r);
              last_r  <= ts_r;
              count_r <= inc_sat(count_r);
            end
            state_r <= S_IDLE;
          end else begin
            k_r     <= k_r + 2'd1;
            state_r <= S_GO;
          end
        end
        S_OUT: begin
          if (!out_valid_r || out_tready) begin
            out_valid_r <= 1'b1;
            out_user_r  <= (count_r != '0);
            out_data_r  <= {overrun_r,
                            avg_r[K_LAT],   max_r[K_LAT],   min_r[K_LAT],
                            avg_r[K_CYCLE], max_r[K_CYCLE], min_r[K_CYCLE],
                            avg_r[K_SCAN],  max_r[K_SCAN],  min_r[K_SCAN],
                            count_r};
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule

[hdl/sctm_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sctm_checker
// port-level checks of the scan cycle timing monitor, bound to the top level
// ----------------------------------------------------------------------------
module sctm_checker (
  input logic                                  clk,
  input logic                                  rst_n,
  input logic                                  in_tvalid,
  input logic                                  in_tready,
  input logic [sctm_pkg::OP_BITS-1:0]          in_tuser,
  input logic                                  out_tvalid,
  input logic                                  out_tready,
  input logic [sctm_pkg::OUT_BITS-1:0]         out_tdata,
  input logic                                  out_tuser
);
  import sctm_pkg::*;

  // stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result word changed while stalled");

  // stats_valid follows the start count
  a_valid_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser == (out_tdata[FIELD_BITS-1:0] != '0)))
    else $error("stats_valid disagrees with the start count");

  // without any start the cycle statistics keep their reset values
  a_no_start: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |->
      out_tdata[4*FIELD_BITS +: FIELD_BITS] == FIELD_MAX &&
      out_tdata[5*FIELD_BITS +: FIELD_BITS] == '0)
    else $error("cycle statistics moved before any start");

  // a snapshot keeps the block busy for its divider passes
  a_snap_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser == OP_SNAP |=> !in_tready)
    else $error("input ready right after a snapshot");

endmodule

bind scan_cycle_timing_monitor sctm_checker u_sctm_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

[test/scan_cycle_timing_monitor_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scan_cycle_timing_monitor_tb
// self-checking bench for the scan cycle timing monitor
// ----------------------------------------------------------------------------
// event words go in on the in_ stream and snapshot words come out on the
// out_ stream. a predictor in the bench tracks the anchors, the min/max
// marks, the ewma sums and the counters, and queues one snapshot word per
// snapshot query. a directed part covers the reset state, saturated
// differences, saturated averages, a zero window, ignored operations and
// register indexes, and a wrapping projection. a random part then runs
// periodic start/end traffic with noise under changing register settings.
// ----------------------------------------------------------------------------
module scan_cycle_timing_monitor_tb;
  import sctm_pkg::*;

  // codes the package leaves out
  localparam logic [OP_BITS-1:0]      OP_UNUSED  = OP_BITS'(3);
  localparam logic [CFG_IDX_BITS-1:0] REG_SPARE2 = CFG_IDX_BITS'(2);
  localparam logic [CFG_IDX_BITS-1:0] REG_SPARE3 = CFG_IDX_BITS'(3);

  // statistic slots in the predictor
  localparam int SCAN_STAT  = 0;
  localparam int CYCLE_STAT = 1;
  localparam int LATE_STAT  = 2;

  localparam int RANDOM_ITEMS  = 500;
  localparam int SETTLE_CYCLES = 250;  // longer than a later start or a snapshot
  localparam int MAX_REPORTS   = 40;

  localparam logic signed [64:0] SUM_TOP    = 65'sh0_7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [64:0] SUM_BOTTOM = -SUM_TOP - 65'sd1;
  localparam logic signed [63:0] AVG_TOP    = 64'sh0000_7FFF_FFFF_FFFF;
  localparam logic signed [63:0] AVG_BOTTOM = -AVG_TOP - 64'sd1;
  localparam logic [TIME_BITS-1:0] ALL_ONES = '1;

  typedef enum int {RX_OPEN, RX_CHOPPY, RX_SLOW} rx_mode_t;

  // one queued snapshot word
  typedef struct packed {
    logic                valid;
    logic [OUT_BITS-1:0] fields;
  } snapshot_t;

  string field_name [OUT_FIELDS] = '{
    "start_total", "scan_lo", "scan_hi", "scan_mean",
    "period_lo", "period_hi", "period_mean",
    "latency_min", "latency_max", "latency_avg", "overrun_count"};

  // dut ports
  logic                      clk        = 1'b0;
  logic                      rst_n      = 1'b0;
  logic                      in_tvalid  = 1'b0;
  logic                      in_tready;
  logic [TIME_BITS-1:0]      in_tdata   = '0;  // timestamp_us
  logic [OP_BITS-1:0]        in_tuser   = '0;  // operation
  logic                      out_tvalid;
  logic                      out_tready = 1'b0;
  // start count, scan min/max/avg, period min/max/avg,
  // latency_min/max/avg, overrun_count (48 bits each, lowest first)
  logic [OUT_BITS-1:0]       out_tdata;
  logic                      out_tuser;        // stats_valid
  logic                      cfg_we     = 1'b0;
  logic [CFG_IDX_BITS-1:0]   cfg_index  = '0;
  logic [CFG_DATA_BITS-1:0]  cfg_wdata  = '0;

  // predictor state
  logic [INTERVAL_BITS-1:0]  period_us;
  logic [WINDOW_BITS-1:0]    window;
  logic [TIME_BITS-1:0]      starts_seen;
  logic [TIME_BITS-1:0]      last_start;
  logic [TIME_BITS-1:0]      next_start;
  logic [TIME_BITS-1:0]      overruns;
  logic signed [FIELD_BITS-1:0] low_mark  [NUM_STATS];
  logic signed [FIELD_BITS-1:0] high_mark [NUM_STATS];
  logic signed [SUM_BITS-1:0]   ewma_sum  [NUM_STATS];

  snapshot_t snapshots_due [$];

  // bookkeeping
  int burst_left;
  int mismatches;
  int snapshots_checked;
  int random_items;
  int starts_sent, ends_sent, snaps_sent, ignored_sent;
  int reg_writes;
  logic [TIME_BITS-1:0] clock_now;  // running task time of the random traffic

  // receiver stall pattern
  rx_mode_t rx_mode = RX_OPEN;
  int       rx_left = 0;

  scan_cycle_timing_monitor u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------- predictor

  function automatic void clear_stats();
    period_us   = RESET_INTERVAL;
    window      = RESET_WINDOW;
    starts_seen = '0;
    last_start  = '0;
    next_start  = '0;
    overruns    = '0;
    for (int k = 0; k < NUM_STATS; k++) begin
      low_mark[k]  = FIELD_MAX;
      high_mark[k] = '0;
      ewma_sum[k]  = '0;
    end
  endfunction

  // exact difference a - b, clamped to the signed field range
  function automatic logic signed [FIELD_BITS-1:0] clamp_diff(
      input logic [TIME_BITS-1:0] a, input logic [TIME_BITS-1:0] b);
    logic signed [TIME_BITS:0] d;
    d = $signed({1'b0, a}) - $signed({1'b0, b});
    if (d > $signed({1'b0, FIELD_MAX})) return FIELD_MAX;
    if (d < $signed({1'b1, FIELD_MIN})) return FIELD_MIN;
    return d[FIELD_BITS-1:0];
  endfunction

  // signed quotient by the window, zero window acts as one
  function automatic logic signed [SUM_BITS-1:0] per_window(
      input logic signed [SUM_BITS-1:0] s);
    logic signed [SUM_BITS-1:0] w;
    w = (window == '0) ? 64'sd1 : $signed({{(SUM_BITS-WINDOW_BITS){1'b0}}, window});
    return s / w;
  endfunction

  // min, max and saturating ewma update of one statistic
  function automatic void fold_sample(input int k, input logic signed [FIELD_BITS-1:0] x);
    logic signed [SUM_BITS:0] acc;
    if (x < low_mark[k])  low_mark[k]  = x;
    if (x > high_mark[k]) high_mark[k] = x;
    acc = ewma_sum[k] - per_window(ewma_sum[k]);
    acc = acc + x;
    if (acc > SUM_TOP)    acc = SUM_TOP;
    if (acc < SUM_BOTTOM) acc = SUM_BOTTOM;
    ewma_sum[k] = acc[SUM_BITS-1:0];
  endfunction

  function automatic logic [FIELD_BITS-1:0] window_avg(input int k);
    logic signed [SUM_BITS-1:0] v;
    v = per_window(ewma_sum[k]);
    if (v > AVG_TOP)    return FIELD_MAX;
    if (v < AVG_BOTTOM) return FIELD_MIN;
    return v[FIELD_BITS-1:0];
  endfunction

  function automatic logic [TIME_BITS-1:0] bump(input logic [TIME_BITS-1:0] c);
    return (c == ALL_ONES) ? c : c + 1'b1;
  endfunction

  // advance the statistics by one accepted event word
  function automatic void apply_timing_event(
      input logic [OP_BITS-1:0] op, input logic [TIME_BITS-1:0] ts);
    snapshot_t snap;
    case (op)
      OP_START: begin
        if (starts_seen != '0) begin
          fold_sample(CYCLE_STAT, clamp_diff(ts, last_start));
          fold_sample(LATE_STAT, clamp_diff(ts, next_start));
          next_start = next_start + period_us;
        end else begin
          // first start only seeds the anchors
          next_start = ts + period_us;
        end
        last_start  = ts;
        starts_seen = bump(starts_seen);
      end
      OP_END: begin
        fold_sample(SCAN_STAT, clamp_diff(ts, last_start));
        if (ts > next_start) overruns = bump(overruns);
      end
      OP_SNAP: begin
        snap.valid = (starts_seen != '0);
        snap.fields[0 +: FIELD_BITS] = starts_seen;
        for (int k = 0; k < NUM_STATS; k++) begin
          snap.fields[(1 + 3*k) * FIELD_BITS +: FIELD_BITS] = low_mark[k];
          snap.fields[(2 + 3*k) * FIELD_BITS +: FIELD_BITS] = high_mark[k];
          snap.fields[(3 + 3*k) * FIELD_BITS +: FIELD_BITS] = window_avg(k);
        end
        snap.fields[(OUT_FIELDS-1) * FIELD_BITS +: FIELD_BITS] = overruns;
        snapshots_due.push_back(snap);
      end
      default: ;  // unknown operation leaves everything alone
    endcase
  endfunction

  // ---------------------------------------------------------------- drivers

  function automatic logic [TIME_BITS-1:0] rand_stamp();
    logic [63:0] r;
    r = {$urandom(), $urandom()};
    return r[TIME_BITS-1:0];
  endfunction

  // send one event word; bursts of random length with random gaps between
  task automatic send_word(input logic [OP_BITS-1:0] op, input logic [TIME_BITS-1:0] ts);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      case ($urandom_range(0, 3))
        0:       gap = 0;                        // back to back
        3:       gap = $urandom_range(20, 140);  // long pause, lands mid-job
        default: gap = $urandom_range(1, 6);
      endcase
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= ts;
    do @(posedge clk); while (!in_tready);
    // word taken at this edge
    apply_timing_event(op, ts);
    case (op)
      OP_START: starts_sent++;
      OP_END:   ends_sent++;
      OP_SNAP:  snaps_sent++;
      default:  ignored_sent++;
    endcase
  endtask

  // stop sending, let every snapshot arrive, then let a busy job finish
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    burst_left = 0;
    while (snapshots_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    // register loads at this edge
    cfg_we <= 1'b0;
    case (idx)
      REG_INTERVAL: period_us = value[INTERVAL_BITS-1:0];
      REG_WINDOW:   window    = value[WINDOW_BITS-1:0];
      default: ;    // spare index, nothing changes
    endcase
    reg_writes++;
  endtask

  // ---------------------------------------------------------------- receiver

  // stall pattern: open stretches, choppy stretches and slow stretches
  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_mode = rx_mode_t'($urandom_range(0, 2));
      rx_left = $urandom_range(16, 400);
    end
    rx_left--;
    case (rx_mode)
      RX_OPEN:   out_tready <= 1'b1;
      RX_CHOPPY: out_tready <= ($urandom_range(0, 1) == 1);
      default:   out_tready <= ($urandom_range(0, 9) == 0);
    endcase
  end

  // compare each snapshot word with the oldest queued expectation
  always @(posedge clk) begin
    snapshot_t due;
    if (rst_n && out_tvalid && out_tready) begin
      if (snapshots_due.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: snapshot word with none expected, stats_valid %b data %h",
                   $time, out_tuser, out_tdata);
      end else begin
        due = snapshots_due.pop_front();
        snapshots_checked++;
        if (out_tuser !== due.valid) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("%0t: stats_valid expected %b got %b", $time, due.valid, out_tuser);
        end
        for (int f = 0; f < OUT_FIELDS; f++) begin
          if (out_tdata[f*FIELD_BITS +: FIELD_BITS] !== due.fields[f*FIELD_BITS +: FIELD_BITS])
          begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
              $display("%0t: %s expected %h got %h", $time, field_name[f],
                       due.fields[f*FIELD_BITS +: FIELD_BITS],
                       out_tdata[f*FIELD_BITS +: FIELD_BITS]);
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------- tests

  // reset statistics, ignored operation, end before any start
  task automatic test_idle_state();
    send_word(OP_SNAP, '0);
    send_word(OP_UNUSED, ALL_ONES);
    send_word(OP_END, ALL_ONES);  // measured against zero anchors, clamps high
    send_word(OP_SNAP, ALL_ONES);
  endtask

  // clamped differences both ways, then averages pushed past the field range
  task automatic test_saturation();
    send_word(OP_START, 48'hFFFF_FFFF_0000);  // projection lands high
    repeat (3) send_word(OP_START, '0);       // lateness clamps low
    repeat (3) send_word(OP_END, ALL_ONES);   // scan time clamps high
    send_word(OP_SNAP, '0);
    wait_idle();
    // upper data bits set, window lands on one
    write_reg(REG_WINDOW, 24'hE0_0001);
    send_word(OP_SNAP, '0);
    wait_idle();
    write_reg(REG_WINDOW, '0);  // zero window counts as one
    send_word(OP_SNAP, '0);
  endtask

  // widest interval wraps the projection; spare indexes are ignored
  task automatic test_projection_wrap();
    wait_idle();
    write_reg(REG_INTERVAL, 24'hFF_FFFF);
    write_reg(REG_SPARE2, 24'h00_0000);
    write_reg(REG_SPARE3, 24'hA5_5A5A);
    send_word(OP_START, ALL_ONES);
    send_word(OP_END, 48'h0000_0000_0100);
    send_word(OP_SNAP, '0);
  endtask

  // noise: ignored ops, anything anywhere, ends and starts behind the clock
  task automatic send_noise();
    case ($urandom_range(0, 3))
      0:       send_word(OP_UNUSED, rand_stamp());
      1:       send_word(OP_BITS'($urandom_range(0, 2)), rand_stamp());
      2:       send_word(OP_END, clock_now - $urandom_range(0, 5000));
      default: send_word(OP_START, clock_now - $urandom_range(0, 5000));
    endcase
  endtask

  // one task period: start on the projected beat with jitter, 0..2 ends,
  // sometimes a snapshot
  task automatic send_period();
    logic [31:0] jitter;
    int unsigned scan_hi;
    jitter = $urandom_range(0, 32'(period_us) / 8 + 16);
    if ($urandom_range(0, 1) == 1) clock_now = clock_now + period_us + jitter;
    else clock_now = clock_now + period_us - jitter;
    send_word(OP_START, clock_now);
    scan_hi = 32'(period_us) + 32'(period_us) / 4 + 40;  // reaches past the next beat
    repeat ($urandom_range(0, 2)) send_word(OP_END, clock_now + $urandom_range(0, scan_hi));
    if ($urandom_range(0, 3) == 0) send_word(OP_SNAP, rand_stamp());
  endtask

  task automatic test_random_traffic();
    int target;
    logic [INTERVAL_BITS-1:0] span;
    logic [WINDOW_BITS-1:0]   win;
    while (random_items < RANDOM_ITEMS) begin
      wait_idle();
      case ($urandom_range(0, 4))
        0:       span = '0;
        1:       span = '1;
        2:       span = RESET_INTERVAL;
        default: span = INTERVAL_BITS'($urandom_range(1, 24'hFF_FFFF));
      endcase
      case ($urandom_range(0, 6))
        0:       win = '0;
        1:       win = WINDOW_BITS'(1);
        2:       win = WINDOW_BITS'(2000000);
        3:       win = '1;
        4:       win = WINDOW_BITS'((span == '0) ? 2000000 : (2000000 / span > 0 ?
                                     2000000 / span : 1));
        default: win = WINDOW_BITS'($urandom_range(1, 2000000));
      endcase
      write_reg(REG_INTERVAL, span);
      write_reg(REG_WINDOW, {3'($urandom_range(0, 7)), win});
      if ($urandom_range(0, 3) == 0) write_reg(REG_SPARE3, 24'($urandom()));
      if ($urandom_range(0, 2) == 0) clock_now = rand_stamp();  // jump, maybe backward
      target = random_items + $urandom_range(30, 70);
      while (random_items < target) begin
        int before_cnt;
        before_cnt = starts_sent + ends_sent + snaps_sent;
        if ($urandom_range(0, 99) < 12) send_noise();
        else send_period();
        random_items += starts_sent + ends_sent + snaps_sent - before_cnt;
        // now and then hold off until every snapshot is back
        if ($urandom_range(0, 59) == 0) wait_idle();
      end
    end
  endtask

  // ---------------------------------------------------------------- sequence

  initial begin
    clear_stats();
    burst_left        = 0;
    mismatches        = 0;
    snapshots_checked = 0;
    random_items      = 0;
    starts_sent       = 0;
    ends_sent         = 0;
    snaps_sent        = 0;
    ignored_sent      = 0;
    reg_writes        = 0;
    clock_now         = rand_stamp();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_idle_state();
    test_saturation();
    test_projection_wrap();
    test_random_traffic();
    wait_idle();

    $display("covered %0d starts, %0d ends, %0d snapshots, %0d ignored words, %0d reg writes",
             starts_sent, ends_sent, snaps_sent, ignored_sent, reg_writes);
    $display("compared %0d snapshot words, %0d mismatches", snapshots_checked, mismatches);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // hang guard, far beyond the slowest correct run
  initial begin
    #10_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
